// ----- src/assert_macros.svh -----
// assertion macros shared by the execute unit
// needs clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define MIEX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked in the same cycle
`define MIEX_ASSERT_IMPL(label, ante, cons, msg) \
  `MIEX_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- src/miex_pkg.sv -----
// types, opcode constants and state encoding for the execute unit
// used by every module of the block but miex_ram
package miex_pkg;

  localparam int DATA_WORDS_DEF = 1024;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 88;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SW      = 6'h2b;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_SLLV = 6'h04;
  localparam logic [5:0] FN_SRLV = 6'h06;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MTHI = 6'h11;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MTLO = 6'h13;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV  = 6'h1a;
  localparam logic [5:0] FN_DIVU = 6'h1b;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  localparam logic [4:0] LINK_REG = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MEM,
    ST_DIV,
    ST_DFIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec_go;
    logic mem_go;
    logic div_start;
    logic div_step;
    logic div_go;
  } cmd_t;

  typedef struct packed {
    logic need_mem;
    logic need_div;
    logic div_last;
  } status_t;

endpackage

// ----- src/miex_ram.sv -----
// generic simple dual port ram, one write port, one registered read port
// no dependencies
module miex_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/miex_ctrl.sv -----
// controller state machine of the execute unit
// depends on miex_pkg for state and command types
module miex_ctrl
  import miex_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.need_mem) begin
          state_nxt = ST_MEM;
        end else if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else if (out_free) begin
          cmd.exec_go = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_MEM: begin
        if (out_free) begin
          cmd.mem_go = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_DFIN;
        end
      end
      ST_DFIN: begin
        if (out_free) begin
          cmd.div_go = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_tready) || cmd.exec_go || cmd.mem_go || cmd.div_go;
  end

endmodule

// ----- src/miex_dp.sv -----
// datapath: register file, hi/lo, data memory, alu, multiplier, divider, result register
// depends on miex_pkg and miex_ram
module miex_dp
  import miex_pkg::*;
#(
  parameter int DATA_WORDS = DATA_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(DATA_WORDS);

  // captured request
  logic        cmd_r;
  logic [31:0] instr_r;
  logic [29:0] pc_r;
  logic [9:0]  pidx_r;
  logic [31:0] pdata_r;

  logic [31:0] hi_r, lo_r;
  logic [31:0] rfv_r;

  // divider
  logic [31:0] rem_r, quo_r, dvs_r;
  logic [4:0]  cnt_r;
  logic        negq_r, negr_r;
  logic [32:0] dtrial;
  logic        dge;
  logic [31:0] rem_nxt;

  // result register
  logic        jv_r, bt_r, wv_r, dz_r, unk_r;
  logic [29:0] jt_r;
  logic [15:0] boff_r;
  logic [4:0]  wi_r;
  logic [31:0] wval_r;
  logic        jv_nxt, bt_nxt, wv_nxt, dz_nxt, unk_nxt;
  logic [29:0] jt_nxt;
  logic [15:0] boff_nxt;
  logic [4:0]  wi_nxt;
  logic [31:0] wval_nxt;

  logic [5:0]  opc, fn;
  logic [4:0]  rsn, rtn, rdn, sh;
  logic [15:0] imm;
  logic [31:0] simm, rs_q, rt_q, rs_v, rt_v, addr;
  logic [4:0]  rd_a, rd_b;

  logic        e_jv, e_bt, e_wv, e_dz, e_unk;
  logic [29:0] e_jt;
  logic [4:0]  e_wi;
  logic [31:0] e_wval;
  logic [63:0] prod;

  logic          rf_we;
  logic [4:0]    rf_wi;
  logic [31:0]   rf_wd;
  logic          dm_we;
  logic [AW-1:0] dm_waddr, dm_raddr;
  logic [31:0]   dm_wdata, dm_rdata, lb_word, sb_word;
  logic [4:0]    lane_sh;

  assign opc  = instr_r[31:26];
  assign rsn  = instr_r[25:21];
  assign rtn  = instr_r[20:16];
  assign rdn  = instr_r[15:11];
  assign sh   = instr_r[10:6];
  assign fn   = instr_r[5:0];
  assign imm  = instr_r[15:0];
  assign simm = {{16{imm[15]}}, imm};

  // read addresses come straight from the request while idle
  assign rd_a = cmd.capture ? in_tdata[25:21] : rsn;
  assign rd_b = cmd.capture ? in_tdata[20:16] : rtn;

  miex_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_wi), .wdata(rf_wd), .raddr(rd_a), .rdata(rs_q)
  );
  miex_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_wi), .wdata(rf_wd), .raddr(rd_b), .rdata(rt_q)
  );

  // entries never written read as zero
  assign rs_v = rfv_r[rsn] ? rs_q : 32'd0;
  assign rt_v = rfv_r[rtn] ? rt_q : 32'd0;
  assign addr = rs_v + simm;

  // DATA_WORDS is to be a power of two, which the block does not check, so the word index wraps by truncation
  assign dm_raddr = AW'(addr[31:2]);
  assign lane_sh  = {addr[1:0], 3'b000};

  miex_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata), .raddr(dm_raddr),
    .rdata(dm_rdata)
  );

  assign lb_word = dm_rdata >> lane_sh;
  assign sb_word = (dm_rdata & ~(32'h0000_00ff << lane_sh)) | ({24'd0, rt_v[7:0]} << lane_sh);

  assign prod = $signed(rs_v) * $signed(rt_v);

  // instruction decode and alu
  always_comb begin
    e_jv   = 1'b0;
    e_bt   = 1'b0;
    e_wv   = 1'b1;
    e_dz   = 1'b0;
    e_unk  = 1'b0;
    e_jt   = '0;
    e_wi   = rtn;
    e_wval = '0;
    if (opc == OP_SPECIAL) begin
      e_wi = rdn;
      unique case (fn)
        FN_SLL:  e_wval = rt_v << sh;
        FN_SRL:  e_wval = rt_v >> sh;
        FN_SRA:  e_wval = $unsigned($signed(rt_v) >>> sh);
        FN_SLLV: e_wval = rt_v << rs_v[4:0];
        FN_SRLV: e_wval = rt_v >> rs_v[4:0];
        FN_JR: begin
          e_wv = 1'b0;
          e_jv = 1'b1;
          e_jt = rs_v[31:2];
        end
        FN_MFHI: e_wval = hi_r;
        FN_MFLO: e_wval = lo_r;
        FN_MTHI, FN_MTLO, FN_MULT: e_wv = 1'b0;
        FN_DIV, FN_DIVU: begin
          e_wv = 1'b0;
          e_dz = (rt_v == 32'd0);
        end
        FN_ADD, FN_ADDU: e_wval = rs_v + rt_v;
        FN_SUB, FN_SUBU: e_wval = rs_v - rt_v;
        FN_AND:  e_wval = rs_v & rt_v;
        FN_OR:   e_wval = rs_v | rt_v;
        FN_XOR:  e_wval = rs_v ^ rt_v;
        FN_SLT:  e_wval = {31'd0, $signed(rs_v) < $signed(rt_v)};
        FN_SLTU: e_wval = {31'd0, rs_v < rt_v};
        default: begin
          e_wv  = 1'b0;
          e_unk = 1'b1;
        end
      endcase
    end else begin
      unique case (opc)
        OP_REGIMM: begin
          e_wv = 1'b0;
          if (rtn == 5'd0) begin
            e_bt = rs_v[31];
          end else begin
            e_unk = 1'b1;
          end
        end
        OP_J, OP_JAL: begin
          e_wv   = (opc == OP_JAL);
          e_wi   = LINK_REG;
          e_wval = {pc_r + 30'd1, 2'b00};
          e_jv   = 1'b1;
          e_jt   = {pc_r[29:26], instr_r[25:0]};
        end
        OP_BEQ: begin
          e_wv = 1'b0;
          e_bt = (rs_v == rt_v);
        end
        OP_BNE: begin
          e_wv = 1'b0;
          e_bt = (rs_v != rt_v);
        end
        OP_BLEZ: begin
          e_wv = 1'b0;
          e_bt = (rs_v == 32'd0) || rs_v[31];
        end
        OP_BGTZ: begin
          e_wv = 1'b0;
          e_bt = (rs_v != 32'd0) && !rs_v[31];
        end
        OP_ADDI, OP_ADDIU: e_wval = rs_v + simm;
        OP_SLTI:  e_wval = {31'd0, $signed(rs_v) < $signed(simm)};
        OP_SLTIU: e_wval = {31'd0, rs_v < simm};
        OP_ANDI:  e_wval = rs_v & {16'd0, imm};
        OP_ORI:   e_wval = rs_v | {16'd0, imm};
        OP_XORI:  e_wval = rs_v ^ {16'd0, imm};
        OP_LUI:   e_wval = {imm, 16'd0};
        OP_LB, OP_LW: e_wval = '0;
        OP_SB, OP_SW: e_wv = 1'b0;
        default: begin
          e_wv  = 1'b0;
          e_unk = 1'b1;
        end
      endcase
    end
  end

  assign status.need_mem = !cmd_r && (opc == OP_LB || opc == OP_LW || opc == OP_SB);
  assign status.need_div = !cmd_r && (opc == OP_SPECIAL) && (fn == FN_DIV || fn == FN_DIVU)
                           && (rt_v != 32'd0);
  assign status.div_last = (cnt_r == 5'd31);

  // write ports
  always_comb begin
    rf_we    = 1'b0;
    rf_wi    = e_wi;
    rf_wd    = e_wval;
    dm_we    = 1'b0;
    dm_waddr = dm_raddr;
    dm_wdata = rt_v;
    if (cmd.exec_go) begin
      if (cmd_r) begin
        dm_we    = 1'b1;
        dm_waddr = AW'({{AW{1'b0}}, pidx_r});
        dm_wdata = pdata_r;
      end else begin
        rf_we = e_wv && (e_wi != 5'd0);
        dm_we = (opc == OP_SW);
      end
    end else if (cmd.mem_go) begin
      if (opc == OP_SB) begin
        dm_we    = 1'b1;
        dm_wdata = sb_word;
      end else begin
        rf_we = (rtn != 5'd0);
        rf_wi = rtn;
        rf_wd = (opc == OP_LB) ? {{24{lb_word[7]}}, lb_word[7:0]} : dm_rdata;
      end
    end
  end

  // divider step, restoring one bit a cycle
  assign dtrial  = {rem_r, quo_r[31]};
  assign dge     = dtrial >= {1'b0, dvs_r};
  assign rem_nxt = dge ? 32'(dtrial - {1'b0, dvs_r}) : dtrial[31:0];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      if (fn == FN_DIV) begin
        quo_r  <= rs_v[31] ? 32'd0 - rs_v : rs_v;
        dvs_r  <= rt_v[31] ? 32'd0 - rt_v : rt_v;
        negq_r <= rs_v[31] ^ rt_v[31];
        negr_r <= rs_v[31];
      end else begin
        quo_r  <= rs_v;
        dvs_r  <= rt_v;
        negq_r <= 1'b0;
        negr_r <= 1'b0;
      end
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[30:0], dge};
      cnt_r <= cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_tuser;
      instr_r <= in_tdata[31:0];
      pc_r    <= in_tdata[61:32];
      pidx_r  <= in_tdata[71:62];
      pdata_r <= in_tdata[103:72];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r  <= '0;
      lo_r  <= '0;
      rfv_r <= '0;
    end else begin
      if (rf_we) begin
        rfv_r[rf_wi] <= 1'b1;
      end
      if (cmd.exec_go && !cmd_r && opc == OP_SPECIAL) begin
        if (fn == FN_MTHI) begin
          hi_r <= rs_v;
        end
        if (fn == FN_MTLO) begin
          lo_r <= rs_v;
        end
        if (fn == FN_MULT) begin
          hi_r <= prod[63:32];
          lo_r <= prod[31:0];
        end
      end
      if (cmd.div_go) begin
        lo_r <= negq_r ? 32'd0 - quo_r : quo_r;
        hi_r <= negr_r ? 32'd0 - rem_r : rem_r;
      end
    end
  end

  // next result
  always_comb begin
    jv_nxt   = 1'b0;
    jt_nxt   = '0;
    bt_nxt   = 1'b0;
    boff_nxt = '0;
    wv_nxt   = 1'b0;
    wi_nxt   = '0;
    wval_nxt = '0;
    dz_nxt   = 1'b0;
    unk_nxt  = 1'b0;
    if (cmd.exec_go && !cmd_r) begin
      jv_nxt   = e_jv;
      jt_nxt   = e_jv ? e_jt : 30'd0;
      bt_nxt   = e_bt;
      boff_nxt = e_bt ? imm : 16'd0;
      wv_nxt   = rf_we;
      wi_nxt   = rf_we ? rf_wi : 5'd0;
      wval_nxt = rf_we ? rf_wd : 32'd0;
      dz_nxt   = e_dz;
      unk_nxt  = e_unk;
    end else if (cmd.mem_go) begin
      wv_nxt   = rf_we;
      wi_nxt   = rf_we ? rf_wi : 5'd0;
      wval_nxt = rf_we ? rf_wd : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_go || cmd.mem_go || cmd.div_go) begin
      jv_r   <= jv_nxt;
      jt_r   <= jt_nxt;
      bt_r   <= bt_nxt;
      boff_r <= boff_nxt;
      wv_r   <= wv_nxt;
      wi_r   <= wi_nxt;
      wval_r <= wval_nxt;
      dz_r   <= dz_nxt;
      unk_r  <= unk_nxt;
    end
  end

  assign out_tdata = {unk_r, dz_r, wval_r, wi_r, wv_r, boff_r, bt_r, jt_r, jv_r};

endmodule

// ----- src/mips_integer_execute_unit.sv -----
// channel  | ports                    | contents
// in       | in_tvalid/tready/tdata/tuser | one instruction or one data memory preload
// out      | out_tvalid/tready/tdata  | jump, branch, register write and flags
//
// an item passes through accept and execute; lb, lw and sb add a memory state for the
// registered data memory read; div and divu with a nonzero divisor add the divide
// and finish states of the one-bit-a-cycle divider; a stalled result adds its wait
// a result waits in the output register while the next request is accepted
// reset is synchronous, active low; register file, hi and lo read zero after it
// depends on miex_pkg, miex_ctrl, miex_dp, miex_ram and assert_macros.svh
`include "assert_macros.svh"

module mips_integer_execute_unit
  import miex_pkg::*;
#(
  parameter int DATA_WORDS = DATA_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // instruction[31:0], pc_word[61:32], preload_index[71:62], preload_data[103:72]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // jump_valid[0], jump_target_word[30:1], branch_taken[31], branch_offset[47:32],
  // reg_write_valid[48], reg_write_index[53:49], reg_write_value[85:54],
  // divide_by_zero[86], unknown_op[87]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cmd_t    cmd;
  status_t status;
  logic    res_load;

  assign res_load = cmd.exec_go || cmd.mem_go || cmd.div_go;

  miex_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .status(status), .cmd(cmd)
  );

  miex_dp #(.DATA_WORDS(DATA_WORDS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .status(status),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tdata(out_tdata)
  );

  `MIEX_ASSERT_IMPL(a_load_free, res_load, !out_tvalid || out_tready, "result overwritten")
  `MIEX_ASSERT(a_one_finish, $onehot0({res_load, cmd.capture}), "two commands in a cycle")
  `MIEX_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready, "accepted while busy")
  `MIEX_ASSERT(a_div_busy, cmd.div_start |=> cmd.div_step && !in_tready, "divider did not step")

endmodule
